### hw/rtl/spsp_pkg.sv
// Shared types and constants for the servo pulse sequencer with park.
`timescale 1ns / 1ps
`default_nettype none

package spsp_pkg;

  localparam int WIDTH_W   = 16;
  localparam int STEP_W    = 10;
  localparam int USED_W    = 17;
  localparam int OP_W      = 2;
  localparam int CHAN_W    = 3;
  localparam int LINES_W   = 5;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SAFE_COUNT = 5;

  localparam logic [WIDTH_W-1:0] FRAME_TICKS_RESET = 16'd50000;
  localparam logic [STEP_W-1:0]  PARK_STEP_RESET   = 10'd10;
  localparam logic [WIDTH_W-1:0] SAFE_WIDTH_RESET  = 16'd3750;
  localparam logic [USED_W-1:0]  USED_MAX          = 17'h1FFFF;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX         = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PARK  = 2'd2
  } op_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FRAME_TICKS = 3'd0;
  localparam cfg_idx_t REG_PARK_STEP   = 3'd1;
  localparam cfg_idx_t REG_SAFE_0      = 3'd2;

  typedef logic [WIDTH_W-1:0] width_t;

  // status of one park lane toward the top level
  typedef struct packed {
    logic   at_target;
    width_t width_next;
  } park_lane_t;

endpackage

`default_nettype wire

### hw/rtl/spsp_if.sv
// Valid/ready channel interfaces for items in and results out.
`timescale 1ns / 1ps
`default_nettype none

interface spsp_in_if import spsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAN_W-1:0]   channel;
  logic [WIDTH_W-1:0]  width;

  modport source (output valid, op, channel, width, input ready);
  modport sink (input valid, op, channel, width, output ready);
endinterface

interface spsp_out_if import spsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LINES_W-1:0]  pulse_lines;
  logic [PHASE_W-1:0]  phase;
  logic [CHAN_W-1:0]   park_channel;
  logic                park_done;

  modport source (output valid, pulse_lines, phase, park_channel, park_done, input ready);
  modport sink (input valid, pulse_lines, phase, park_channel, park_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/spsp_park_lane.sv
// One channel's park ramp: next width toward safe plus step, and target check.
`timescale 1ns / 1ps
`default_nettype none

module spsp_park_lane import spsp_pkg::*; (
  input  wire width_t            width_cur,
  input  wire width_t            safe_width,
  input  wire logic [STEP_W-1:0] park_step,
  output park_lane_t             status
);

  logic [WIDTH_W:0] target_sum;
  width_t           target;
  width_t           step16;
  width_t           diff;

  assign target_sum = {1'b0, safe_width} + (WIDTH_W+1)'(park_step);
  assign target     = target_sum[WIDTH_W] ? WIDTH_MAX : target_sum[WIDTH_W-1:0];
  assign step16     = WIDTH_W'(park_step);

  always_comb begin
    status.at_target  = 1'b0;
    status.width_next = width_cur;
    diff              = '0;
    if (width_cur > target) begin
      diff = width_cur - target;
      status.width_next = (diff > step16) ? width_cur - step16 : target;
    end else if (width_cur < target) begin
      // width + step stays below target here, so no overflow
      diff = target - width_cur;
      status.width_next = (diff > step16) ? width_cur + step16 : target;
    end else begin
      status.at_target = 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/servo_pulse_sequencer_with_park_core.sv
// Top level: frame sequencer, width registers, park control and result register.
// An accepted item's result beat is registered in the output register.
// One item per cycle unless stalled; the frame/park state updates in a single pass.
// The input is ready whenever the output register is empty or drained that cycle.
// Reset (rst, synchronous): config to defaults, widths to safe widths, phase 0,
// park index 0, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module servo_pulse_sequencer_with_park_core import spsp_pkg::*; #(
  parameter int CHANNELS = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire cfg_idx_t             cfg_index,
  input  wire logic [WIDTH_W-1:0]   cfg_data,
  spsp_in_if.sink                   items,
  spsp_out_if.source                results
);

  localparam int PW = $clog2(CHANNELS + 1);

  // configuration
  width_t            frame_ticks;
  logic [STEP_W-1:0] park_step;
  width_t            safe_width [SAFE_COUNT];

  // sequencer state
  width_t            tick_count;
  logic [PW-1:0]     frame_phase;
  width_t            active_length;
  logic [USED_W-1:0] used_in_frame;
  width_t            channel_widths [CHANNELS];
  logic [PW-1:0]     park_index;
  logic              park_finished;

  logic              accept;
  logic [PW-1:0]     phase_inc;
  width_t            dur;
  logic [WIDTH_W:0]  cnt;
  logic [USED_W:0]   used_sum;
  logic [USED_W-1:0] used_sat;
  width_t            gap_length;
  width_t            width_entry;
  logic [LINES_W-1:0] lines;
  park_lane_t        lane [CHANNELS];
  logic              park_active;
  logic              park_hit;
  logic [PW-1:0]     park_index_next;
  logic              park_finished_next;

  assign accept = items.valid && items.ready;
  assign items.ready = !results.valid || results.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks <= FRAME_TICKS_RESET;
      park_step   <= PARK_STEP_RESET;
      for (int k = 0; k < SAFE_COUNT; k++) safe_width[k] <= SAFE_WIDTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_TICKS) frame_ticks <= cfg_data;
      if (cfg_index == REG_PARK_STEP) park_step <= cfg_data[STEP_W-1:0];
      for (int k = 0; k < SAFE_COUNT; k++) begin
        if (cfg_index == REG_SAFE_0 + CFG_IDX_W'(k)) safe_width[k] <= cfg_data;
      end
    end
  end

  // park lanes, one per channel
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    width_t lane_safe;
    if (k < SAFE_COUNT) begin : g_safe
      assign lane_safe = safe_width[k];
    end else begin : g_nosafe
      assign lane_safe = '0;
    end
    spsp_park_lane u_lane (
      .width_cur  (channel_widths[k]),
      .safe_width (lane_safe),
      .park_step  (park_step),
      .status     (lane[k])
    );
  end

  // tick datapath
  assign phase_inc = frame_phase + PW'(1);
  assign dur       = (active_length != '0) ? active_length : WIDTH_W'(1);
  assign cnt       = {1'b0, tick_count} + (WIDTH_W+1)'(1);
  assign used_sum  = {1'b0, used_in_frame} + (USED_W+1)'(active_length);
  assign used_sat  = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];

  always_comb begin
    if (used_sat >= USED_W'(frame_ticks)) gap_length = WIDTH_W'(1);
    else gap_length = frame_ticks - used_sat[WIDTH_W-1:0];
  end

  always_comb begin
    width_entry = channel_widths[0];
    for (int k = 0; k < CHANNELS; k++) begin
      if (int'(phase_inc) == k) width_entry = channel_widths[k];
    end
  end

  // park control
  always_comb begin
    park_hit = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (int'(park_index) == k && lane[k].at_target) park_hit = 1'b1;
    end
  end

  assign park_active = accept && (op_t'(items.op) == OP_PARK) && !park_finished &&
                       (int'(park_index) < CHANNELS);

  always_comb begin
    park_index_next    = park_index;
    park_finished_next = park_finished;
    if (park_active && park_hit) begin
      park_index_next = park_index + PW'(1);
      if (int'(park_index_next) >= CHANNELS) park_finished_next = 1'b1;
    end
  end

  // sequencer and width registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      frame_phase   <= '0;
      active_length <= SAFE_WIDTH_RESET;
      used_in_frame <= '0;
      park_index    <= '0;
      park_finished <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        channel_widths[k] <= (k < SAFE_COUNT) ? SAFE_WIDTH_RESET : '0;
      end
    end else begin
      park_index    <= park_index_next;
      park_finished <= park_finished_next;
      if (accept) begin
        case (op_t'(items.op))
          OP_TICK: begin
            if (cnt < {1'b0, dur}) begin
              tick_count <= cnt[WIDTH_W-1:0];
            end else if (int'(frame_phase) < CHANNELS) begin
              tick_count    <= '0;
              used_in_frame <= used_sat;
              frame_phase   <= phase_inc;
              active_length <= (int'(phase_inc) < CHANNELS) ? width_entry : gap_length;
            end else begin
              tick_count    <= '0;
              used_in_frame <= '0;
              frame_phase   <= '0;
              active_length <= channel_widths[0];
            end
          end
          OP_WRITE: begin
            for (int k = 0; k < CHANNELS; k++) begin
              if (int'(items.channel) == k) channel_widths[k] <= items.width;
            end
          end
          OP_PARK: begin
            if (park_active && !park_hit) begin
              for (int k = 0; k < CHANNELS; k++) begin
                if (int'(park_index) == k) channel_widths[k] <= lane[k].width_next;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // line view of the current phase
  always_comb begin
    lines = '0;
    for (int k = 0; k < LINES_W; k++) begin
      if (k < CHANNELS && int'(frame_phase) == k && active_length != '0) lines[k] = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.pulse_lines  <= lines;
      results.phase        <= PHASE_W'(frame_phase);
      results.park_channel <= CHAN_W'(park_index_next);
      results.park_done    <= park_finished_next;
    end
  end

  // checks
  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    park_finished |-> (int'(park_index) == CHANNELS))
    else $error("park done without index at end");

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    (int'(frame_phase) == CHANNELS) |-> (active_length != '0))
    else $error("gap phase with zero length");

  a_tick_in_phase: assert property (@(posedge clk) disable iff (rst)
    (tick_count < dur))
    else $error("tick count beyond phase length");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> items.ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
